### rtl/msc_pkg.sv
// Package: shared types, codes and address helpers of the MESI snooping cache controller.
`default_nettype none

package msc_pkg;

  // MESI line states
  typedef enum logic [1:0] {
    ST_I = 2'd0,
    ST_S = 2'd1,
    ST_E = 2'd2,
    ST_M = 2'd3
  } mesi_t;

  // request kinds
  localparam logic [1:0] KIND_CPU_RD = 2'd0;
  localparam logic [1:0] KIND_CPU_WR = 2'd1;
  localparam logic [1:0] KIND_SNP_RD = 2'd2;
  localparam logic [1:0] KIND_SNP_WR = 2'd3;

  // result status codes
  localparam logic [1:0] STAT_HIT     = 2'd0;
  localparam logic [1:0] STAT_MISS    = 2'd1;
  localparam logic [1:0] STAT_BUSY    = 2'd2;
  localparam logic [1:0] STAT_PENDING = 2'd3;

  // bus request codes
  localparam logic [1:0] BREQ_NONE  = 2'd0;
  localparam logic [1:0] BREQ_RD    = 2'd1;
  localparam logic [1:0] BREQ_RDX   = 2'd2;
  localparam logic [1:0] BREQ_UPGR  = 2'd3;

  // configuration register indexes
  localparam logic [1:0] CFG_SET_BITS   = 2'd0;
  localparam logic [1:0] CFG_BLOCK_BITS = 2'd1;
  localparam logic [1:0] CFG_WAYS       = 2'd2;
  localparam logic [1:0] CFG_OWN_ID     = 2'd3;

  localparam logic [7:0] MEM_CYCLES = 8'd100;

  // one result as produced by the lookup logic
  typedef struct packed {
    logic [1:0] status;
    logic       snoop_hit;
    logic [1:0] bus_req;
    logic [1:0] way;
    logic [1:0] nst;
    logic       wb;
    logic       ev;
    logic       inv;
    logic [7:0] cyc;
    logic [9:0] bytes;
  } msc_result_t;

  // array update controls from the lookup logic
  typedef struct packed {
    logic  state_we;
    logic  tag_we;
    logic  stamp_we;
    mesi_t nst;
  } msc_upd_t;

  // set number of an address (not yet cut to the index width)
  function automatic logic [31:0] addr_set(input logic [31:0] addr,
                                           input logic [3:0] sb,
                                           input logic [3:0] bb);
    addr_set = (addr >> bb) & ((32'd1 << sb) - 32'd1);
  endfunction

  // tag of an address
  function automatic logic [31:0] addr_tag(input logic [31:0] addr,
                                           input logic [3:0] sb,
                                           input logic [3:0] bb);
    addr_tag = addr >> ({1'b0, sb} + {1'b0, bb});
  endfunction

endpackage

`default_nettype wire

### rtl/msc_set_ram.sv
// Set row memory (tags, stamps and MESI states), registered read with write forwarding.
`default_nettype none

module msc_set_ram #(
  parameter int ADDR_W = 6,
  parameter int DEPTH  = 64,
  parameter int DATA_W = 256
) (
  input  wire logic              clk,
  input  wire logic              re,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [DATA_W-1:0] rdata,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [DATA_W-1:0] wdata
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rdata_r;

  // write the row
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read the row; pass a same-edge write straight through
  always_ff @(posedge clk) begin
    if (re) begin
      if (we && (waddr == raddr)) begin
        rdata_r <= wdata;
      end else begin
        rdata_r <= mem[raddr];
      end
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

### rtl/msc_lookup.sv
// Lookup logic: way compare, victim choice and MESI transitions for one request.
`default_nettype none

module msc_lookup #(
  parameter int WAYS  = 4,
  parameter int WAY_W = 2
) (
  input  wire logic [1:0]             kind,
  input  wire logic [3:0]             requester,
  input  wire logic                   bus_busy,
  input  wire logic [3:0]             bus_owner,
  input  wire logic                   remote_has_copy,
  input  wire logic                   data_wanted,
  input  wire logic [3:0]             own_id,
  input  wire logic [2:0]             nways,
  input  wire logic [3:0]             bb,
  input  wire logic [31:0]            tag,
  input  wire msc_pkg::mesi_t [WAYS-1:0] st_row,
  input  wire logic [WAYS-1:0][31:0]  tags,
  input  wire logic [WAYS-1:0][31:0]  stamps,
  output msc_pkg::msc_result_t        res,
  output msc_pkg::msc_upd_t           upd,
  output logic      [WAY_W-1:0]       upd_way
);

  import msc_pkg::*;

  logic             hit;
  int               hit_i;
  logic [WAY_W-1:0] hit_way;
  logic             inv_found;
  int               vic_i;
  logic [31:0]      min_stamp;
  logic [WAY_W-1:0] vic_way;
  mesi_t            hit_st;
  mesi_t            vic_st;
  logic [8:0]       bsize;
  logic             wr;

  // find the lowest valid way whose tag matches
  always_comb begin
    hit   = 1'b0;
    hit_i = 0;
    for (int w = 0; w < WAYS; w++) begin
      if ((w < int'(nways)) && !hit && (st_row[w] != ST_I) && (tags[w] == tag)) begin
        hit   = 1'b1;
        hit_i = w;
      end
    end
  end

  // pick the first invalid way, else the oldest stamp (lowest way on a tie)
  always_comb begin
    inv_found = 1'b0;
    vic_i     = 0;
    min_stamp = stamps[0];
    for (int w = 0; w < WAYS; w++) begin
      if ((w < int'(nways)) && !inv_found) begin
        if (st_row[w] == ST_I) begin
          inv_found = 1'b1;
          vic_i     = w;
        end else if (stamps[w] < min_stamp) begin
          min_stamp = stamps[w];
          vic_i     = w;
        end
      end
    end
  end

  assign hit_way = WAY_W'(hit_i);
  assign vic_way = WAY_W'(vic_i);
  assign hit_st  = st_row[hit_way];
  assign vic_st  = st_row[vic_way];
  assign bsize   = 9'd1 << bb;
  assign wr      = (kind == KIND_CPU_WR);

  // decide the outcome and the array updates
  always_comb begin
    res     = '0;
    upd     = '0;
    upd.nst = ST_I;
    upd_way = hit_way;
    priority if ((kind == KIND_SNP_RD) || (kind == KIND_SNP_WR)) begin
      if ((requester != own_id) && hit) begin
        res.snoop_hit = 1'b1;
        res.way       = 2'(hit_i);
        upd.state_we  = 1'b1;
        upd.nst       = hit_st;
        if (hit_st == ST_M) begin
          res.wb    = 1'b1;
          res.cyc   = MEM_CYCLES;
          res.bytes = {1'b0, bsize};
        end
        if (kind == KIND_SNP_WR) begin
          upd.nst = ST_I;
        end else begin
          if ((hit_st == ST_E) || (hit_st == ST_M)) begin
            upd.nst = ST_S;
          end
          if (data_wanted) begin
            res.bytes = res.bytes + {1'b0, bsize};
            res.cyc   = res.cyc + 8'(bsize >> 1);
          end
        end
        res.nst = upd.nst;
      end
    end else if (bus_busy && (bus_owner == requester)) begin
      res.status = STAT_PENDING;
    end else if (hit) begin
      if (wr && (hit_st != ST_M) && bus_busy) begin
        res.status = STAT_BUSY;
      end else begin
        upd.state_we = 1'b1;
        upd.stamp_we = 1'b1;
        upd.nst      = hit_st;
        if (wr && (hit_st != ST_M)) begin
          res.inv     = (hit_st == ST_S);
          res.bus_req = BREQ_UPGR;
          upd.nst     = ST_M;
        end
        res.way = 2'(hit_i);
        res.nst = upd.nst;
      end
    end else if (bus_busy) begin
      res.status = STAT_BUSY;
    end else begin
      // fill the victim way
      res.status   = STAT_MISS;
      upd_way      = vic_way;
      upd.state_we = 1'b1;
      upd.tag_we   = 1'b1;
      upd.stamp_we = 1'b1;
      if (vic_st == ST_M) begin
        res.wb    = 1'b1;
        res.cyc   = MEM_CYCLES;
        res.bytes = {1'b0, bsize};
      end
      res.ev = (vic_st != ST_I);
      if (wr) begin
        res.bus_req = BREQ_RDX;
        res.inv     = remote_has_copy;
        res.cyc     = res.cyc + MEM_CYCLES;
        upd.nst     = ST_M;
      end else begin
        res.bus_req = BREQ_RD;
        if (remote_has_copy) begin
          upd.nst = ST_S;
        end else begin
          res.cyc = res.cyc + MEM_CYCLES;
          upd.nst = ST_E;
        end
      end
      res.bytes = res.bytes + {1'b0, bsize};
      res.way   = 2'(vic_i);
      res.nst   = upd.nst;
    end
  end

endmodule

`default_nettype wire

### rtl/mesi_snooping_cache_controller.sv
// Top level: MESI snooping cache tag controller with stream request and result channels.
//
// Usage: requests enter on the in_ stream (in_tuser carries the kind: cpu read or
// write, snoop read or write; in_tdata the address, requester, bus status, remote
// copy and data-wanted flags and the timestamp). One result per request leaves on
// the out_ stream with status, bus request, way, new line state, event flags, bus
// cycles and bytes. The cfg_ port writes set index bits, block bits, ways in use
// and the own core id, one register per write; the user must write only while the
// block is idle, which the block does not enforce. A request is held in the lookup
// stage registers, its result in the output register. A request per cycle is taken
// while the receiver does not stall; the set row (tags, stamps and MESI states) is read
// from memory at acceptance, the lookup runs in the following cycle and the row is
// written back at its end, with the written row forwarded to a request that reads
// the same set at that edge. Reset: configuration returns to 6 set bits, 32-byte
// blocks, 4 ways and core 0; a clearing pass then writes all 1 << MAX_SET_BITS set
// rows (64 by default) to zero (all lines invalid), one set per cycle, with in_tready
// low until it ends. When the receiver stalls the result is held in the output
// register, the request in the lookup stage waits and in_tready drops.
`default_nettype none

module mesi_snooping_cache_controller #(
  parameter int MAX_SET_BITS = 6,
  parameter int WAYS         = 4
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // fields from bit 0: address[31:0], requester[35:32], bus_busy[36],
  // bus_owner[40:37], remote_has_copy[41], data_wanted[42], timestamp[74:43]
  input  wire logic [79:0] in_tdata,
  // fields from bit 0: kind[1:0]
  input  wire logic [1:0]  in_tuser,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // fields from bit 0: status[1:0], snoop_hit[2], bus_request[4:3], way_used[6:5],
  // line_state_after[8:7], wrote_back[9], evicted[10], invalidation[11],
  // bus_cycles[19:12], traffic_bytes[29:20]
  output logic [31:0]      out_tdata,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [3:0]  cfg_wdata
);

  import msc_pkg::*;

  localparam int SETS   = 1 << MAX_SET_BITS;
  localparam int SET_W  = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
  localparam int WAY_W  = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int ROW_W  = WAYS * 66;

  // configuration registers
  logic [2:0] cfg_sib_r;
  logic [3:0] cfg_bb_r;
  logic [2:0] cfg_ways_r;
  logic [3:0] cfg_own_r;

  logic [3:0] eff_sb;
  logic [3:0] eff_bb;
  logic [4:0] ways_ext;
  logic [2:0] eff_ways;

  // lookup stage registers
  logic        s1_valid_r;
  logic [1:0]  s1_kind_r;
  logic [31:0] s1_addr_r;
  logic [3:0]  s1_req_r;
  logic        s1_busy_r;
  logic [3:0]  s1_owner_r;
  logic        s1_remote_r;
  logic        s1_wanted_r;
  logic [31:0] s1_stamp_r;

  // output register
  logic        out_valid_r;
  logic [31:0] out_tdata_r;

  // clearing pass after reset
  logic             clr_active_r;
  logic [SET_W-1:0] clr_addr_r;

  logic             in_accept;
  logic             s1_adv;
  logic [31:0]      in_set_full;
  logic [SET_W-1:0] in_set;
  logic [31:0]      s1_set_full;
  logic [SET_W-1:0] s1_set;
  logic [31:0]      s1_tag;

  logic [ROW_W-1:0]       rd_row;
  logic [WAYS-1:0][31:0]  rd_tags;
  logic [WAYS-1:0][31:0]  rd_stamps;
  logic [WAYS-1:0][1:0]   rd_st_bits;
  mesi_t [WAYS-1:0]       rd_states;
  logic [WAYS-1:0][31:0]  wr_tags;
  logic [WAYS-1:0][31:0]  wr_stamps;
  mesi_t [WAYS-1:0]       wr_states;
  logic                   row_we;
  logic                   ram_we;
  logic [SET_W-1:0]       ram_waddr;
  logic [ROW_W-1:0]       ram_wdata;

  msc_result_t      res;
  msc_upd_t         upd;
  logic [WAY_W-1:0] upd_way;

  // saturate the configuration into its working ranges
  assign eff_sb   = ({1'b0, cfg_sib_r} > 4'(MAX_SET_BITS)) ? 4'(MAX_SET_BITS)
                                                           : {1'b0, cfg_sib_r};
  assign eff_bb   = (cfg_bb_r < 4'd2) ? 4'd2 : ((cfg_bb_r > 4'd8) ? 4'd8 : cfg_bb_r);
  assign ways_ext = (cfg_ways_r == 3'd0) ? 5'd1
                  : (({2'b0, cfg_ways_r} > 5'(WAYS)) ? 5'(WAYS) : {2'b0, cfg_ways_r});
  assign eff_ways = ways_ext[2:0];

  // write configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_sib_r  <= 3'd6;
      cfg_bb_r   <= 4'd5;
      cfg_ways_r <= 3'd4;
      cfg_own_r  <= 4'd0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_SET_BITS:   cfg_sib_r  <= cfg_wdata[2:0];
        CFG_BLOCK_BITS: cfg_bb_r   <= cfg_wdata;
        CFG_WAYS:       cfg_ways_r <= cfg_wdata[2:0];
        CFG_OWN_ID:     cfg_own_r  <= cfg_wdata;
      endcase
    end
  end

  // walk every set once after reset, writing an all-invalid row
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_active_r <= 1'b1;
      clr_addr_r   <= '0;
    end else if (clr_active_r) begin
      if (clr_addr_r == SET_W'(SETS - 1)) begin
        clr_active_r <= 1'b0;
      end
      clr_addr_r <= clr_addr_r + SET_W'(1);
    end
  end

  // handshake: advance the lookup stage when the output register frees up
  assign s1_adv    = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !clr_active_r && (!s1_valid_r || s1_adv);
  assign in_accept = in_tvalid && in_tready;

  // set of the incoming request, used as the row read address
  assign in_set_full = addr_set(in_tdata[31:0], eff_sb, eff_bb);
  assign in_set      = in_set_full[SET_W-1:0];

  // set and tag of the request in the lookup stage
  assign s1_set_full = addr_set(s1_addr_r, eff_sb, eff_bb);
  assign s1_set      = s1_set_full[SET_W-1:0];
  assign s1_tag      = addr_tag(s1_addr_r, eff_sb, eff_bb);

  // lookup stage control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_accept) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  // capture the request payload
  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_kind_r   <= in_tuser;
      s1_addr_r   <= in_tdata[31:0];
      s1_req_r    <= in_tdata[35:32];
      s1_busy_r   <= in_tdata[36];
      s1_owner_r  <= in_tdata[40:37];
      s1_remote_r <= in_tdata[41];
      s1_wanted_r <= in_tdata[42];
      s1_stamp_r  <= in_tdata[74:43];
    end
  end

  // split the row into tags, stamps and MESI states
  assign rd_tags    = rd_row[WAYS*32-1:0];
  assign rd_stamps  = rd_row[WAYS*64-1:WAYS*32];
  assign rd_st_bits = rd_row[ROW_W-1:WAYS*64];

  always_comb begin
    for (int w = 0; w < WAYS; w++) begin
      rd_states[w] = mesi_t'(rd_st_bits[w]);
    end
  end

  msc_set_ram #(
    .ADDR_W (SET_W),
    .DEPTH  (SETS),
    .DATA_W (ROW_W)
  ) u_ram (
    .clk   (clk),
    .re    (in_accept),
    .raddr (in_set),
    .rdata (rd_row),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata)
  );

  msc_lookup #(
    .WAYS  (WAYS),
    .WAY_W (WAY_W)
  ) u_lookup (
    .kind            (s1_kind_r),
    .requester       (s1_req_r),
    .bus_busy        (s1_busy_r),
    .bus_owner       (s1_owner_r),
    .remote_has_copy (s1_remote_r),
    .data_wanted     (s1_wanted_r),
    .own_id          (cfg_own_r),
    .nways           (eff_ways),
    .bb              (eff_bb),
    .tag             (s1_tag),
    .st_row          (rd_states),
    .tags            (rd_tags),
    .stamps          (rd_stamps),
    .res             (res),
    .upd             (upd),
    .upd_way         (upd_way)
  );

  // merge the new tag, stamp and state into the row
  always_comb begin
    wr_tags   = rd_tags;
    wr_stamps = rd_stamps;
    wr_states = rd_states;
    if (upd.tag_we) begin
      wr_tags[upd_way] = s1_tag;
    end
    if (upd.stamp_we) begin
      wr_stamps[upd_way] = s1_stamp_r;
    end
    if (upd.state_we) begin
      wr_states[upd_way] = upd.nst;
    end
  end

  assign row_we = s1_adv && (upd.state_we || upd.tag_we || upd.stamp_we);

  // the clearing pass owns the write port until it ends
  assign ram_we    = clr_active_r || row_we;
  assign ram_waddr = clr_active_r ? clr_addr_r : s1_set;
  assign ram_wdata = clr_active_r ? '0 : {wr_states, wr_stamps, wr_tags};

  // output register control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  // load the result
  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_tdata_r <= {2'b00, res.bytes, res.cyc, res.inv, res.ev, res.wb, res.nst,
                      res.way, res.bus_req, res.snoop_hit, res.status};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_tdata_r;

endmodule

`default_nettype wire
